/* rtl/kvlp_pkg.sv */
// kvlp_pkg: types, character codes, state table and classifier for the
// key/value line parser. No dependencies; imported by every other rtl file.
package kvlp_pkg;

	localparam int KVLP_MAX_VALUES = 16;
	localparam int KVLP_LINE_LEN   = 1024;

	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_BLANK   = 8'h20;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		CL_HASH   = 3'd0,
		CL_BLANK  = 3'd1,
		CL_COMMA  = 3'd2,
		CL_QUOTE  = 3'd3,
		CL_EQUALS = 3'd4,
		CL_END    = 3'd5,
		CL_OTHER  = 3'd6
	} kvlp_class_t;

	// 0..15 are stored machine states, the rest are table outcomes only
	typedef enum logic [4:0] {
		ST_S0 = 5'd0,  ST_C0 = 5'd1,  ST_K0 = 5'd2,  ST_K1 = 5'd3,
		ST_K2 = 5'd4,  ST_V0 = 5'd5,  ST_V1 = 5'd6,  ST_V2 = 5'd7,
		ST_V3 = 5'd8,  ST_V4 = 5'd9,  ST_V5 = 5'd10, ST_Q0 = 5'd11,
		ST_Q1 = 5'd12, ST_Q2 = 5'd13, ST_Q3 = 5'd14, ST_Q4 = 5'd15,
		ST_E0 = 5'd16, ST_E1 = 5'd17, ST_E2 = 5'd18, ST_E3 = 5'd19,
		ST_E4 = 5'd20, ST_E5 = 5'd21, ST_X0 = 5'd22
	} kvlp_state_t;

	typedef enum logic [3:0] {
		EV_NONE       = 4'd0,
		EV_KEY_BEGIN  = 4'd1,
		EV_KEY_CHAR   = 4'd2,
		EV_SLOT_OPEN  = 4'd3,
		EV_VAL_BEGIN  = 4'd4,
		EV_VAL_CHAR   = 4'd5,
		EV_OPEN_BEGIN = 4'd6,
		EV_LINE_OK    = 4'd7,
		EV_ERROR      = 4'd8
	} kvlp_event_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_BAD_KEY     = 3'd1,
		ERR_NO_KEY      = 3'd2,
		ERR_BLANK_KEY   = 3'd3,
		ERR_BAD_VALUE   = 3'd4,
		ERR_NO_QUOTE    = 3'd5,
		ERR_AFTER_QUOTE = 3'd6,
		ERR_TOO_MANY    = 3'd7
	} kvlp_error_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_line;
	} kvlp_in_t;

	typedef struct packed {
		logic [3:0]  event_res;
		logic [2:0]  error_code;
		logic [10:0] position;
		logic [3:0]  value_slot;
		logic [10:0] key_length;
		logic [10:0] value_length;
		logic [4:0]  value_count;
	} kvlp_out_t;

	// columns: hash, blank, comma, quote, equals, end, other
	localparam kvlp_state_t NEXT_TAB [0:15][0:6] = '{
		'{ST_C0, ST_S0, ST_E0, ST_E0, ST_E1, ST_X0, ST_K0},
		'{ST_C0, ST_C0, ST_C0, ST_C0, ST_C0, ST_X0, ST_C0},
		'{ST_C0, ST_K2, ST_E0, ST_E0, ST_V0, ST_X0, ST_K1},
		'{ST_C0, ST_K2, ST_E0, ST_E0, ST_V0, ST_X0, ST_K1},
		'{ST_C0, ST_K2, ST_E0, ST_E0, ST_V0, ST_X0, ST_E2},
		'{ST_C0, ST_V3, ST_V0, ST_Q0, ST_E3, ST_X0, ST_V1},
		'{ST_C0, ST_V4, ST_V0, ST_E3, ST_E3, ST_X0, ST_V2},
		'{ST_C0, ST_V4, ST_V0, ST_E3, ST_E3, ST_X0, ST_V2},
		'{ST_C0, ST_V3, ST_V0, ST_Q0, ST_E3, ST_X0, ST_V1},
		'{ST_C0, ST_V4, ST_V0, ST_Q1, ST_E3, ST_X0, ST_V5},
		'{ST_C0, ST_V4, ST_V0, ST_E3, ST_E3, ST_X0, ST_V2},
		'{ST_Q2, ST_Q2, ST_Q2, ST_Q4, ST_Q2, ST_E4, ST_Q2},
		'{ST_Q2, ST_Q2, ST_Q2, ST_Q4, ST_Q2, ST_E4, ST_Q2},
		'{ST_Q3, ST_Q3, ST_Q3, ST_Q4, ST_Q3, ST_E4, ST_Q3},
		'{ST_Q3, ST_Q3, ST_Q3, ST_Q4, ST_Q3, ST_E4, ST_Q3},
		'{ST_C0, ST_V4, ST_V0, ST_E5, ST_E5, ST_X0, ST_E5}
	};

	function automatic kvlp_class_t char_class(input logic [7:0] c, input logic eol);
		kvlp_class_t cls;
		cls = CL_OTHER;
		if (eol || c == CH_NEWLINE) begin
			cls = CL_END;
		end else begin
			unique case (c)
				CH_HASH:   cls = CL_HASH;
				CH_BLANK:  cls = CL_BLANK;
				CH_COMMA:  cls = CL_COMMA;
				CH_QUOTE:  cls = CL_QUOTE;
				CH_EQUALS: cls = CL_EQUALS;
				default:   cls = CL_OTHER;
			endcase
		end
		return cls;
	endfunction

endpackage

/* rtl/kvlp_step.sv */
// kvlp_step: combinational next-state and event logic for one character.
// Depends on kvlp_pkg (table, classifier, codes, result struct).
module kvlp_step import kvlp_pkg::*; #(
	parameter int MAX_VALUES = KVLP_MAX_VALUES,
	parameter int LINE_LEN   = KVLP_LINE_LEN,
	localparam int CW = $clog2(LINE_LEN + 1),
	localparam int SW = $clog2(MAX_VALUES + 1)
) (
	input  kvlp_in_t    word,
	input  kvlp_state_t state_cur,
	input  logic [CW-1:0] index_cur,
	input  logic [CW-1:0] key_cur,
	input  logic [SW-1:0] slot_cur,
	input  logic [CW-1:0] vlen_cur,
	input  logic          discard_cur,
	output kvlp_state_t   state_nxt,
	output logic [CW-1:0] index_nxt,
	output logic [CW-1:0] key_nxt,
	output logic [SW-1:0] slot_nxt,
	output logic [CW-1:0] vlen_nxt,
	output logic          discard_nxt,
	output kvlp_out_t     result
);

	localparam logic [CW-1:0] LEN_MAX  = CW'(LINE_LEN);
	localparam logic [SW-1:0] SLOT_MAX = SW'(MAX_VALUES);

	kvlp_class_t   cls;
	kvlp_state_t   nx;
	kvlp_state_t   state_u;
	kvlp_event_t   ev;
	kvlp_error_t   err;
	logic          line_done;
	logic          disc_u;
	logic [CW-1:0] key_u;
	logic [CW-1:0] vlen_u;
	logic [SW-1:0] slot_u;
	logic [SW-1:0] slot_idx;
	logic [CW+10:0] pos_x;
	logic [CW+10:0] key_x;
	logic [CW+10:0] vlen_x;
	logic [SW+4:0]  cnt_x;
	logic [SW+4:0]  sidx_x;

	always_comb begin
		cls       = char_class(word.ch, word.end_of_line);
		line_done = (cls == CL_END);
		nx        = NEXT_TAB[state_cur[3:0]][cls];
		ev        = EV_NONE;
		err       = ERR_NONE;
		state_u   = state_cur;
		disc_u    = discard_cur;
		key_u     = key_cur;
		vlen_u    = vlen_cur;
		slot_u    = slot_cur;
		if (!discard_cur) begin
			unique case (nx)
				ST_K0: begin
					key_u = CW'(1);
					ev    = EV_KEY_BEGIN;
				end
				ST_K1: begin
					key_u = (key_cur < LEN_MAX) ? key_cur + 1'b1 : LEN_MAX;
					ev    = EV_KEY_CHAR;
				end
				ST_V0, ST_Q1, ST_V5: begin
					if (slot_cur >= SLOT_MAX) begin
						ev  = EV_ERROR;
						err = ERR_TOO_MANY;
					end else begin
						slot_u = slot_cur + 1'b1;
						if (nx == ST_V5) begin
							vlen_u = CW'(1);
							ev     = EV_OPEN_BEGIN;
						end else begin
							vlen_u = '0;
							ev     = EV_SLOT_OPEN;
						end
					end
				end
				ST_V1, ST_Q2: begin
					vlen_u = CW'(1);
					ev     = EV_VAL_BEGIN;
				end
				ST_V2, ST_Q3: begin
					vlen_u = (vlen_cur < LEN_MAX) ? vlen_cur + 1'b1 : LEN_MAX;
					ev     = EV_VAL_CHAR;
				end
				ST_E0: begin ev = EV_ERROR; err = ERR_BAD_KEY;     end
				ST_E1: begin ev = EV_ERROR; err = ERR_NO_KEY;      end
				ST_E2: begin ev = EV_ERROR; err = ERR_BLANK_KEY;   end
				ST_E3: begin ev = EV_ERROR; err = ERR_BAD_VALUE;   end
				ST_E4: begin ev = EV_ERROR; err = ERR_NO_QUOTE;    end
				ST_E5: begin ev = EV_ERROR; err = ERR_AFTER_QUOTE; end
				ST_X0: ev = EV_LINE_OK;
				default: ;
			endcase
			if (ev == EV_ERROR) begin
				disc_u = 1'b1;
			end else if (!nx[4]) begin
				state_u = nx;
			end
		end

		// fields are the low bits of the counters
		slot_idx = (slot_u != '0) ? slot_u - 1'b1 : '0;
		pos_x    = (CW+11)'(index_cur);
		key_x    = (CW+11)'(key_u);
		vlen_x   = (CW+11)'(vlen_u);
		cnt_x    = (SW+5)'(slot_u);
		sidx_x   = (SW+5)'(slot_idx);

		result.event_res    = ev;
		result.error_code   = err;
		result.position     = pos_x[10:0];
		result.value_slot   = sidx_x[3:0];
		result.key_length   = key_x[10:0];
		result.value_length = vlen_x[10:0];
		result.value_count  = cnt_x[4:0];

		// line end clears everything for the next line
		if (line_done) begin
			state_nxt   = ST_S0;
			index_nxt   = '0;
			key_nxt     = '0;
			slot_nxt    = '0;
			vlen_nxt    = '0;
			discard_nxt = 1'b0;
		end else begin
			state_nxt   = state_u;
			index_nxt   = (index_cur < LEN_MAX) ? index_cur + 1'b1 : LEN_MAX;
			key_nxt     = key_u;
			slot_nxt    = slot_u;
			vlen_nxt    = vlen_u;
			discard_nxt = disc_u;
		end
	end

endmodule

/* rtl/key_value_line_parser.sv */
// key_value_line_parser: top level with input register, parser state and
// result register. Depends on kvlp_pkg and kvlp_step.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one word per line
//   character: ch plus end_of_line. A newline character or end_of_line
//   closes the line and returns the parser to its start state.
//   result channel (result_valid/result_ready/result) returns exactly one
//   word per item: event, error code, position, value slot, key length,
//   value length and value count.
// Path: an accepted item goes through the input register, then the result
//   register. Throughput: one word per cycle while result_ready stays high.
//   The rate is set by the single pass of table lookup plus counter
//   update between the input register and the result register.
// Stall: while result_ready is low, the result register holds its word and
//   the input register still takes one more word; item_ready drops only
//   when both are full.
// Reset (arst_n low): both registers empty, parser at start state, all
//   counters zero, discard flag clear.
// After an error the rest of the line yields event none until its end.
module key_value_line_parser import kvlp_pkg::*; #(
	parameter int MAX_VALUES = KVLP_MAX_VALUES,
	parameter int LINE_LEN   = KVLP_LINE_LEN
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  kvlp_in_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output kvlp_out_t result
);

	localparam int CW = $clog2(LINE_LEN + 1);
	localparam int SW = $clog2(MAX_VALUES + 1);

	// input stage
	kvlp_in_t  item_s1;
	logic      valid_s1;
	// result stage
	kvlp_out_t result_s2;
	logic      valid_s2;

	// parser state
	kvlp_state_t   state_q;
	logic [CW-1:0] index_q;
	logic [CW-1:0] key_q;
	logic [SW-1:0] slot_q;
	logic [CW-1:0] vlen_q;
	logic          discard_q;

	kvlp_state_t   state_d;
	logic [CW-1:0] index_d;
	logic [CW-1:0] key_d;
	logic [SW-1:0] slot_d;
	logic [CW-1:0] vlen_d;
	logic          discard_d;
	kvlp_out_t     result_d;

	logic advance;
	logic take;
	logic line_end_s1;

	// s1 moves into s2 whenever s2 is empty or being drained
	assign advance     = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready  = !valid_s1 || advance;
	assign take        = item_valid && item_ready;
	assign line_end_s1 = (char_class(item_s1.ch, item_s1.end_of_line) == CL_END);

	kvlp_step #(
		.MAX_VALUES(MAX_VALUES),
		.LINE_LEN  (LINE_LEN)
	) u_step (
		.word       (item_s1),
		.state_cur  (state_q),
		.index_cur  (index_q),
		.key_cur    (key_q),
		.slot_cur   (slot_q),
		.vlen_cur   (vlen_q),
		.discard_cur(discard_q),
		.state_nxt  (state_d),
		.index_nxt  (index_d),
		.key_nxt    (key_d),
		.slot_nxt   (slot_d),
		.vlen_nxt   (vlen_d),
		.discard_nxt(discard_d),
		.result     (result_d)
	);

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	// parser state commits as the word leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_S0;
			index_q   <= '0;
			key_q     <= '0;
			slot_q    <= '0;
			vlen_q    <= '0;
			discard_q <= 1'b0;
		end else if (advance) begin
			state_q   <= state_d;
			index_q   <= index_d;
			key_q     <= key_d;
			slot_q    <= slot_d;
			vlen_q    <= vlen_d;
			discard_q <= discard_d;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// error code is present exactly on error events
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.event_res == EV_ERROR) == (result.error_code != ERR_NONE)))
		else $error("error code and event disagree");

	// a line end leaves the parser fully cleared
	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && line_end_s1) |=> (state_q == ST_S0 && index_q == '0 && key_q == '0
			&& slot_q == '0 && vlen_q == '0 && !discard_q))
		else $error("parser not cleared after line end");

	// discard mode lasts until the line ends
	a_discard_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(discard_q && !(advance && line_end_s1)) |=> discard_q)
		else $error("discard dropped before line end");

	// slot count never passes the limit
	a_slot_limit: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SW'(MAX_VALUES))
		else $error("slot count over limit");

	// a held input word keeps its contents until it moves on
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input stage lost a word");

endmodule

/* bench/testbench.sv */
// testbench: self-checking bench for key_value_line_parser, one character
// word in and one event word out. Depends on kvlp_pkg and the parser rtl.
`timescale 1ns / 100ps

module testbench;
	import kvlp_pkg::*;

	localparam int HOLD_CYCLES = 60;    // long receiver hold-off, fills the parser
	localparam int IDLE_LIMIT  = 2000;  // watchdog: cycles with no word moving
	localparam int MAIN_ITEMS  = 700;   // random part with idling
	localparam int TOTAL_ITEMS = 850;   // tail of the random part runs without idling
	localparam logic [10:0] LEN_CAP  = 11'(KVLP_LINE_LEN);
	localparam logic [4:0]  SLOT_CAP = 5'(KVLP_MAX_VALUES);

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	kvlp_in_t  item_word = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	kvlp_out_t result_word;

	kvlp_in_t  char_queue[$];   // words waiting for the driver
	kvlp_out_t event_due[$];    // predicted events, oldest first
	kvlp_in_t  line_buf[$];     // line under construction

	int  queued = 0;
	int  bad_words = 0;
	int  idle_cycles = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	bit  quiet = 1'b0;      // no idling on either side
	bit  hold_go = 1'b0;
	bit  rx_hold = 1'b0;

	// predictor state
	kvlp_state_t pstate = ST_S0;
	logic [10:0] at_char = '0;
	logic [10:0] key_chars = '0;
	logic [10:0] val_chars = '0;
	logic [4:0]  slots = '0;
	bit          skip_rest = 1'b0;

	key_value_line_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [10:0] bump(input logic [10:0] v);
		return (v < LEN_CAP) ? v + 11'd1 : LEN_CAP;
	endfunction

	function automatic kvlp_class_t char_kind(input kvlp_in_t w);
		if (w.end_of_line || w.ch == CH_NEWLINE) return CL_END;
		case (w.ch)
			CH_HASH:   return CL_HASH;
			CH_BLANK:  return CL_BLANK;
			CH_COMMA:  return CL_COMMA;
			CH_QUOTE:  return CL_QUOTE;
			CH_EQUALS: return CL_EQUALS;
			default:   return CL_OTHER;
		endcase
	endfunction

	// transition table, written row group by row group
	function automatic kvlp_state_t next_state(input kvlp_state_t s, input kvlp_class_t c);
		kvlp_state_t n;
		n = ST_S0;
		case (s)
			ST_S0: begin
				case (c)
					CL_HASH:            n = ST_C0;
					CL_BLANK:           n = ST_S0;
					CL_COMMA, CL_QUOTE: n = ST_E0;
					CL_EQUALS:          n = ST_E1;
					CL_END:             n = ST_X0;
					default:            n = ST_K0;
				endcase
			end
			ST_C0: n = (c == CL_END) ? ST_X0 : ST_C0;
			ST_K0, ST_K1, ST_K2: begin
				case (c)
					CL_HASH:            n = ST_C0;
					CL_BLANK:           n = ST_K2;
					CL_COMMA, CL_QUOTE: n = ST_E0;
					CL_EQUALS:          n = ST_V0;
					CL_END:             n = ST_X0;
					default:            n = (s == ST_K2) ? ST_E2 : ST_K1;
				endcase
			end
			ST_V0, ST_V3: begin
				case (c)
					CL_HASH:   n = ST_C0;
					CL_BLANK:  n = ST_V3;
					CL_COMMA:  n = ST_V0;
					CL_QUOTE:  n = ST_Q0;
					CL_EQUALS: n = ST_E3;
					CL_END:    n = ST_X0;
					default:   n = ST_V1;
				endcase
			end
			ST_V1, ST_V2, ST_V5: begin
				case (c)
					CL_HASH:             n = ST_C0;
					CL_BLANK:            n = ST_V4;
					CL_COMMA:            n = ST_V0;
					CL_QUOTE, CL_EQUALS: n = ST_E3;
					CL_END:              n = ST_X0;
					default:             n = ST_V2;
				endcase
			end
			ST_V4: begin
				case (c)
					CL_HASH:   n = ST_C0;
					CL_BLANK:  n = ST_V4;
					CL_COMMA:  n = ST_V0;
					CL_QUOTE:  n = ST_Q1;
					CL_EQUALS: n = ST_E3;
					CL_END:    n = ST_X0;
					default:   n = ST_V5;
				endcase
			end
			ST_Q0, ST_Q1, ST_Q2, ST_Q3: begin
				if (c == CL_QUOTE) n = ST_Q4;
				else if (c == CL_END) n = ST_E4;
				else n = (s == ST_Q0 || s == ST_Q1) ? ST_Q2 : ST_Q3;
			end
			ST_Q4: begin
				case (c)
					CL_HASH:  n = ST_C0;
					CL_BLANK: n = ST_V4;
					CL_COMMA: n = ST_V0;
					CL_END:   n = ST_X0;
					default:  n = ST_E5;
				endcase
			end
			default: n = ST_S0;
		endcase
		return n;
	endfunction

	// advances the predictor by one character word, returns the event word
	function automatic kvlp_out_t parse_step(input kvlp_in_t w);
		kvlp_out_t   r;
		kvlp_class_t c;
		kvlp_state_t n;
		kvlp_event_t ev;
		kvlp_error_t er;
		logic [10:0] here;
		c = char_kind(w);
		ev = EV_NONE;
		er = ERR_NONE;
		here = at_char;
		if (!skip_rest) begin
			n = next_state(pstate, c);
			case (n)
				ST_K0: begin key_chars = 11'd1; ev = EV_KEY_BEGIN; end
				ST_K1: begin key_chars = bump(key_chars); ev = EV_KEY_CHAR; end
				ST_V0, ST_Q1, ST_V5: begin
					// every slot opener runs into the value limit
					if (slots >= SLOT_CAP) begin
						ev = EV_ERROR;
						er = ERR_TOO_MANY;
					end else begin
						slots = slots + 5'd1;
						if (n == ST_V5) begin
							val_chars = 11'd1;
							ev = EV_OPEN_BEGIN;
						end else begin
							val_chars = '0;
							ev = EV_SLOT_OPEN;
						end
					end
				end
				ST_V1, ST_Q2: begin val_chars = 11'd1; ev = EV_VAL_BEGIN; end
				ST_V2, ST_Q3: begin val_chars = bump(val_chars); ev = EV_VAL_CHAR; end
				ST_E0: begin ev = EV_ERROR; er = ERR_BAD_KEY; end
				ST_E1: begin ev = EV_ERROR; er = ERR_NO_KEY; end
				ST_E2: begin ev = EV_ERROR; er = ERR_BLANK_KEY; end
				ST_E3: begin ev = EV_ERROR; er = ERR_BAD_VALUE; end
				ST_E4: begin ev = EV_ERROR; er = ERR_NO_QUOTE; end
				ST_E5: begin ev = EV_ERROR; er = ERR_AFTER_QUOTE; end
				ST_X0: ev = EV_LINE_OK;
				default: ;
			endcase
			if (ev == EV_ERROR) skip_rest = 1'b1;
			else if (n < ST_E0) pstate = n;
		end
		r.event_res    = ev;
		r.error_code   = er;
		r.position     = here;
		r.value_slot   = (slots != '0) ? 4'(slots - 5'd1) : 4'd0;
		r.key_length   = key_chars;
		r.value_length = val_chars;
		r.value_count  = slots;
		if (c == CL_END) begin
			pstate = ST_S0;
			at_char = '0;
			key_chars = '0;
			val_chars = '0;
			slots = '0;
			skip_rest = 1'b0;
		end else begin
			at_char = bump(at_char);
		end
		return r;
	endfunction

	// driver: offers the next queued word, holds it until taken
	always @(posedge clk) begin : drive_chars
		bit give;
		give = 1'b0;
		if (arst_n) begin
			if (item_valid && item_ready) event_due.push_back(parse_step(item_word));
			if (!item_valid || item_ready) begin
				if (tx_gap != 0) begin
					tx_gap--;
				end else if (char_queue.size() != 0) begin
					if (!quiet && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(0, 3);
					else give = 1'b1;
				end
				if (give) begin
					item_word <= char_queue.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: takes event words, checks them against the oldest prediction
	always @(posedge clk) begin : check_events
		kvlp_out_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (event_due.size() == 0) begin
					if (bad_words < 10)
						$display("unexpected event word ev=%0d pos=%0d", result_word.event_res,
							result_word.position);
					bad_words++;
				end else begin
					want = event_due.pop_front();
					if (result_word.event_res !== want.event_res ||
					    result_word.error_code !== want.error_code ||
					    result_word.position !== want.position ||
					    result_word.value_slot !== want.value_slot ||
					    result_word.key_length !== want.key_length ||
					    result_word.value_length !== want.value_length ||
					    result_word.value_count !== want.value_count) begin
						if (bad_words < 10)
							$display({"mismatch: expected ev=%0d err=%0d pos=%0d slot=%0d ",
								"key=%0d val=%0d cnt=%0d, got ev=%0d err=%0d pos=%0d ",
								"slot=%0d key=%0d val=%0d cnt=%0d"},
								want.event_res, want.error_code, want.position,
								want.value_slot, want.key_length, want.value_length,
								want.value_count, result_word.event_res,
								result_word.error_code, result_word.position,
								result_word.value_slot, result_word.key_length,
								result_word.value_length, result_word.value_count);
						bad_words++;
					end
				end
			end
			if (rx_hold) begin
				result_ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				result_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(0, 3);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// watchdog on words moving in either direction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", idle_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// receiver hold-off, counted here while the sender keeps offering
	initial begin : receiver_hold
		wait (hold_go);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
	end

	function automatic bit is_special(input logic [7:0] c);
		return c == CH_HASH || c == CH_BLANK || c == CH_COMMA || c == CH_QUOTE ||
			c == CH_EQUALS || c == CH_NEWLINE;
	endfunction

	// key or unquoted value character
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		if ($urandom_range(0, 1)) begin
			c = 8'h61 + 8'($urandom_range(0, 25));
		end else begin
			c = 8'($urandom_range(0, 255));
			while (is_special(c)) c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	// anything but the closing quote or a newline
	function automatic logic [7:0] quoted_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == CH_QUOTE || c == CH_NEWLINE) c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// noise, weighted toward the characters the table reacts to
	function automatic logic [7:0] any_char();
		case ($urandom_range(0, 11))
			0: return CH_HASH;
			1: return CH_BLANK;
			2: return CH_COMMA;
			3: return CH_QUOTE;
			4: return CH_EQUALS;
			5: return CH_NEWLINE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic put(input logic [7:0] c, input bit eol = 1'b0);
		kvlp_in_t w;
		w.ch = c;
		w.end_of_line = eol;
		line_buf.push_back(w);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endtask

	// line end: the flag with a random character, or a plain newline
	task automatic close_line();
		if ($urandom_range(0, 1)) put(8'($urandom_range(0, 255)), 1'b1);
		else put(CH_NEWLINE);
	endtask

	// hands the line to the driver, optionally corrupting one character
	task automatic ship(input bit mangle = 1'b0);
		int k;
		if (mangle && line_buf.size() > 1) begin
			k = $urandom_range(0, line_buf.size() - 2);
			line_buf[k].ch = any_char();
		end
		queued += line_buf.size();
		while (line_buf.size() != 0) char_queue.push_back(line_buf.pop_front());
	endtask

	task automatic good_line();
		int nv;
		int r;
		repeat ($urandom_range(0, 1)) put(CH_BLANK);
		if ($urandom_range(0, 9) == 0) begin
			put(CH_HASH);
			repeat ($urandom_range(0, 4)) put(quoted_char());
		end else begin
			repeat ($urandom_range(1, 5)) put(plain_char());
			repeat ($urandom_range(0, 1)) put(CH_BLANK);
			put(CH_EQUALS);
			repeat ($urandom_range(0, 1)) put(CH_BLANK);
			r = $urandom_range(0, 19);
			if (r == 0) nv = 0;
			else if (r == 1) nv = $urandom_range(15, 18);
			else nv = $urandom_range(1, 4);
			for (int i = 0; i < nv; i++) begin
				if (i > 0) begin
					case ($urandom_range(0, 4))
						0: put(CH_BLANK);
						1: put(CH_COMMA);
						2: begin put(CH_BLANK); put(CH_COMMA); end
						3: begin put(CH_COMMA); put(CH_BLANK); end
						default: begin put(CH_COMMA); put(CH_COMMA); end
					endcase
				end
				if ($urandom_range(0, 3) == 0) begin
					put(CH_QUOTE);
					repeat ($urandom_range(0, 3)) put(quoted_char());
					put(CH_QUOTE);
				end else begin
					repeat ($urandom_range(1, 4)) put(plain_char());
				end
			end
			if ($urandom_range(0, 4) == 0) put(CH_BLANK);
			if ($urandom_range(0, 5) == 0) begin
				put(CH_HASH);
				repeat ($urandom_range(0, 3)) put(quoted_char());
			end
		end
		close_line();
	endtask

	task automatic random_line();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14) begin
			good_line();
			ship();
		end else if (r < 17) begin
			good_line();
			ship(1'b1);
		end else begin
			repeat ($urandom_range(0, 12)) put(any_char());
			close_line();
			ship();
		end
	endtask

	// n values; style 0 comma only, else blank and comma separators with every third value quoted
	task automatic many_values(input int n, input int style);
		put_str("k=");
		for (int i = 0; i < n; i++) begin
			if (style == 0) begin
				if (i > 0) put(CH_COMMA);
				put(plain_char());
			end else begin
				if (i > 0) put((i % 3 == 0) ? CH_COMMA : CH_BLANK);
				if (i % 3 == 2) begin
					put(CH_QUOTE);
					put(plain_char());
					put(CH_QUOTE);
				end else begin
					put(plain_char());
				end
			end
		end
		close_line();
		ship();
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (char_queue.size() != 0 || item_valid || event_due.size() != 0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines
		put(8'hFF, 1'b1);                       // empty line, flag end
		ship();
		put(8'hFF); put_str("=\""); put(8'h00); // key 0xFF, quoted NUL, blank, then b
		put_str("\" b"); put(CH_NEWLINE);
		ship();
		put_str("="); put(8'h00, 1'b1);         // no key
		ship();
		put_str("a b"); put(CH_NEWLINE);        // blank inside key
		ship();
		put_str(","); put(CH_NEWLINE);          // bad first key char
		ship();
		put_str("k=\""); put(8'h0A, 1'b1);      // line ends inside quotes
		ship();
		put_str("k=\"\"x"); put(CH_NEWLINE);    // character right after closing quote
		ship();
		wait_drained();

		// receiver stalls long while the sender keeps going
		hold_go = 1'b1;
		while (queued < 140) begin
			good_line();
			ship();
		end
		wait_drained();

		// value limit from both kinds of openers
		many_values(17, 0);
		many_values(18, 1);
		many_values(16, 0);
		wait_drained();

		while (queued < MAIN_ITEMS) random_line();
		wait_drained();

		quiet = 1'b1;
		while (queued < TOTAL_ITEMS) random_line();
		wait_drained();

		repeat (10) @(negedge clk);
		if (bad_words == 0 && event_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* key_value_line_parser.f */
rtl/kvlp_pkg.sv
rtl/kvlp_step.sv
rtl/key_value_line_parser.sv
bench/testbench.sv
